// File: sv/relay_bank_pulse_timers_assert.svh
`ifndef RELAY_BANK_PULSE_TIMERS_ASSERT_SVH
`define RELAY_BANK_PULSE_TIMERS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RBPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("relay bank timer property failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RBPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("relay bank timer property failed");

`endif

// File: sv/rbpt_pkg.sv
package rbpt_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int TIME_W   = 32;
    localparam int LEVELS_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OFF   = 2'd0,
        ACT_ON    = 2'd1,
        ACT_TIMED = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    // Per-cell control: load wins over shift.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// File: sv/rbpt_cmd_if.sv
interface rbpt_cmd_if;
    import rbpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  relay_index;
    logic [TIME_W-1:0]   duration_ms;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, action, relay_index, duration_ms, now_ms, input ready);
    modport sink   (input valid, action, relay_index, duration_ms, now_ms, output ready);
endinterface

// File: sv/rbpt_evt_if.sv
interface rbpt_evt_if;
    import rbpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  event_relay;
    logic                event_level;
    logic [LEVELS_W-1:0] relay_levels;
    logic                last_event;

    modport source (output valid, event_relay, event_level, relay_levels, last_event,
                    input ready);
    modport sink   (input valid, event_relay, event_level, relay_levels, last_event,
                    output ready);
endinterface

// File: sv/rbpt_cell.sv
module rbpt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbpt_pkg::t_cell_ctl           i_ctl,
    input  logic [rbpt_pkg::TIME_W-1:0]   i_shift_count,
    input  logic [rbpt_pkg::TIME_W-1:0]   i_load_count,
    output logic [rbpt_pkg::TIME_W-1:0]   o_count
);
    import rbpt_pkg::*;

    logic [TIME_W-1:0] r_count;
    logic [TIME_W-1:0] n_count;

    // A zero count means the timer is disarmed.
    always_comb begin
        n_count = r_count;
        if (i_ctl.load) begin
            n_count = i_load_count;
        end else if (i_ctl.shift) begin
            n_count = i_shift_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// File: sv/relay_bank_pulse_timers.sv
// Bank of RELAYS relay outputs with one-shot off-timers. An off or on command
// drives one relay and returns one item in the cycle after it is accepted; a
// timed-on command also loads that relay's countdown (a duration of zero
// leaves the relay on for good, and timed-on for channel 0 is dropped). A
// command whose index is not below RELAYS returns nothing. A tick carries the
// millisecond time; the wrapped time since the previous tick is taken off
// every armed countdown, and each countdown that is not above it switches its
// relay off and returns an item, in ascending channel order, the final one
// flagged by last_event. The countdowns sit in a ring of RELAYS cells that
// rotates once per tick through a single compare-and-subtract unit at its
// head, so a tick is taken in the idle state, steps through the ring one
// position at a time in the scan state and then ends in a closing state; the
// scan and the closing state may wait while the result side stalls. A command
// leaves the block idle.
// A new item is taken only when the block is idle and its output register is
// empty or being drained. relay_levels shows channels 0 to 15 only.
module relay_bank_pulse_timers #(
    parameter int RELAYS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbpt_cmd_if.sink    i_cmd,
    rbpt_evt_if.source  o_evt
);
    import rbpt_pkg::*;

    localparam int POS_W = $clog2(RELAYS);
    localparam int VIS_W = (RELAYS < LEVELS_W) ? RELAYS : LEVELS_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RELAYS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } t_state;

    // Maps the internal level vector onto the 16-bit visible field.
    function automatic logic [LEVELS_W-1:0] f_vis(input logic [RELAYS-1:0] lv);
        logic [LEVELS_W-1:0] v;
        v = '0;
        v[VIS_W-1:0] = lv[VIS_W-1:0];
        return v;
    endfunction

    t_state              r_state,     n_state;
    logic [RELAYS-1:0]   r_levels,    n_levels;
    logic [TIME_W-1:0]   r_last_tick, n_last_tick;
    logic [TIME_W-1:0]   r_elapsed,   n_elapsed;
    logic [POS_W-1:0]    r_pos,       n_pos;

    // One expired event is held back until we know whether another follows,
    // so that the final event of a tick can carry last_event.
    logic                r_pv,        n_pv;
    logic [INDEX_W-1:0]  r_p_relay,   n_p_relay;
    logic [LEVELS_W-1:0] r_p_lvls,    n_p_lvls;

    // Output register.
    logic                r_ov,        n_ov;
    logic [INDEX_W-1:0]  r_o_relay,   n_o_relay;
    logic                r_o_level,   n_o_level;
    logic [LEVELS_W-1:0] r_o_lvls,    n_o_lvls;
    logic                r_o_last,    n_o_last;

    logic [TIME_W-1:0]   w_count [RELAYS];
    t_cell_ctl           w_ctl   [RELAYS];
    logic [TIME_W-1:0]   w_head;
    logic [TIME_W-1:0]   w_head_new;
    logic                w_armed;
    logic                w_expire;
    logic                w_shift;
    logic                w_out_free;
    logic                w_in_acc;
    logic                w_idx_ok;
    logic                w_cmd_ok;
    logic                w_timed_load;
    logic [POS_W-1:0]    w_chan;

    // Head of the ring: the channel at position r_pos is tested here and its
    // updated count goes back in at the tail.
    assign w_head     = w_count[0];
    assign w_armed    = (w_head != '0);
    assign w_expire   = w_armed && (w_head <= r_elapsed);
    assign w_head_new = (w_expire || !w_armed) ? '0 : (w_head - r_elapsed);

    assign w_out_free = !r_ov || o_evt.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_cmd.valid && i_cmd.ready;

    assign w_idx_ok = {1'b0, i_cmd.relay_index} < (INDEX_W + 1)'(RELAYS);
    assign w_cmd_ok = w_idx_ok &&
                      !((i_cmd.action == ACT_TIMED) && (i_cmd.relay_index == '0));
    assign w_chan   = i_cmd.relay_index[POS_W-1:0];
    assign w_timed_load = w_in_acc && w_cmd_ok && (i_cmd.action == ACT_TIMED);

    genvar k;
    generate
        for (k = 0; k < RELAYS; k++) begin : g_cell
            logic [TIME_W-1:0] w_shift_in;

            if (k == RELAYS - 1) begin : g_tail
                assign w_shift_in = w_head_new;
            end else begin : g_mid
                assign w_shift_in = w_count[k+1];
            end

            assign w_ctl[k].shift = w_shift;
            assign w_ctl[k].load  = w_timed_load && (w_chan == POS_W'(k));

            rbpt_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl[k]),
                .i_shift_count (w_shift_in),
                .i_load_count  (i_cmd.duration_ms),
                .o_count       (w_count[k])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_levels    = r_levels;
        n_last_tick = r_last_tick;
        n_elapsed   = r_elapsed;
        n_pos       = r_pos;
        n_pv        = r_pv;
        n_p_relay   = r_p_relay;
        n_p_lvls    = r_p_lvls;
        n_ov        = r_ov && !o_evt.ready;
        n_o_relay   = r_o_relay;
        n_o_level   = r_o_level;
        n_o_lvls    = r_o_lvls;
        n_o_last    = r_o_last;
        w_shift     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_cmd.action == ACT_TICK) begin
                        n_elapsed   = i_cmd.now_ms - r_last_tick;
                        n_last_tick = i_cmd.now_ms;
                        n_pos       = '0;
                        n_state     = S_SCAN;
                    end else if (w_cmd_ok) begin
                        n_levels[w_chan] = (i_cmd.action != ACT_OFF);
                        n_ov      = 1'b1;
                        n_o_relay = i_cmd.relay_index;
                        n_o_level = (i_cmd.action != ACT_OFF);
                        n_o_lvls  = f_vis(n_levels);
                        n_o_last  = 1'b1;
                    end
                end
            end

            S_SCAN: begin
                // An expiry needs room for the held event; otherwise the ring
                // waits in place.
                if (!w_expire || !r_pv || w_out_free) begin
                    w_shift = 1'b1;
                    if (w_expire) begin
                        n_levels[r_pos] = 1'b0;
                        if (r_pv) begin
                            n_ov      = 1'b1;
                            n_o_relay = r_p_relay;
                            n_o_level = 1'b0;
                            n_o_lvls  = r_p_lvls;
                            n_o_last  = 1'b0;
                        end
                        n_pv      = 1'b1;
                        n_p_relay = INDEX_W'(r_pos);
                        n_p_lvls  = f_vis(n_levels);
                    end
                    if (r_pos == LAST_POS) begin
                        n_state = S_LAST;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end

            S_LAST: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_o_relay = r_p_relay;
                    n_o_level = 1'b0;
                    n_o_lvls  = r_p_lvls;
                    n_o_last  = 1'b1;
                    n_pv      = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_levels    <= '0;
            r_last_tick <= '0;
            r_pos       <= '0;
            r_pv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_levels    <= n_levels;
            r_last_tick <= n_last_tick;
            r_pos       <= n_pos;
            r_pv        <= n_pv;
            r_ov        <= n_ov;
        end
        r_elapsed <= n_elapsed;
        r_p_relay <= n_p_relay;
        r_p_lvls  <= n_p_lvls;
        r_o_relay <= n_o_relay;
        r_o_level <= n_o_level;
        r_o_lvls  <= n_o_lvls;
        r_o_last  <= n_o_last;
    end

    assign o_evt.valid        = r_ov;
    assign o_evt.event_relay  = r_o_relay;
    assign o_evt.event_level  = r_o_level;
    assign o_evt.relay_levels = r_o_lvls;
    assign o_evt.last_event   = r_o_last;

endmodule

// File: sv/rbpt_checker.sv
module rbpt_checker #(
    parameter int RELAYS = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic [rbpt_pkg::ACTION_W-1:0]   i_in_action,
    input logic [rbpt_pkg::INDEX_W-1:0]    i_in_relay_index,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [rbpt_pkg::INDEX_W-1:0]    i_out_event_relay,
    input logic                            i_out_event_level,
    input logic [rbpt_pkg::LEVELS_W-1:0]   i_out_relay_levels,
    input logic                            i_out_last_event
);
    import rbpt_pkg::*;

    `include "relay_bank_pulse_timers_assert.svh"

    logic w_on_cmd;

    assign w_on_cmd = i_in_valid && i_in_ready && (i_in_action == ACT_ON) &&
                      ({1'b0, i_in_relay_index} < (INDEX_W + 1)'(RELAYS));

    // An accepted switch-on shows up as a lone on event for that channel.
    `RBPT_ASSERT_NEXT(a_on_echo, i_clk, i_rst_n, w_on_cmd, i_out_valid && i_out_event_level && i_out_last_event && (i_out_event_relay == $past(i_in_relay_index)))

    // Only commands drive a relay on, and each gives exactly one event.
    `RBPT_ASSERT_NOW(a_on_is_last, i_clk, i_rst_n, i_out_valid && i_out_event_level, i_out_last_event)

    // The level snapshot agrees with the event for visible channels.
    `RBPT_ASSERT_NOW(a_levels_match, i_clk, i_rst_n, i_out_valid && (i_out_event_relay < INDEX_W'(LEVELS_W)), i_out_relay_levels[i_out_event_relay[3:0]] == i_out_event_level)

    // A stalled event holds.
    `RBPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_event_relay) && $stable(i_out_relay_levels))

endmodule

bind relay_bank_pulse_timers rbpt_checker #(.RELAYS(RELAYS)) u_rbpt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_cmd.valid),
    .i_in_ready         (i_cmd.ready),
    .i_in_action        (i_cmd.action),
    .i_in_relay_index   (i_cmd.relay_index),
    .i_out_valid        (o_evt.valid),
    .i_out_ready        (o_evt.ready),
    .i_out_event_relay  (o_evt.event_relay),
    .i_out_event_level  (o_evt.event_level),
    .i_out_relay_levels (o_evt.relay_levels),
    .i_out_last_event   (o_evt.last_event)
);
